// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own behavior.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/trm_pkg.sv =====
// Shared types and constants of the transfer rate meter.
// Depends on nothing; used by every module of the block.
package trm_pkg;

    // One second in microseconds, consumed four bits per cycle by the scaler.
    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam int DIGIT_W = 4;
    localparam int USEC_DIGITS = USEC_W / DIGIT_W;
    localparam int DIGIT_IDX_W = $clog2(USEC_DIGITS);

    localparam int RATE_W = 60;
    localparam int SUM_W = 40;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_INIT  = 2'd3
    } trm_op_t;

    // Order in which the rates are recomputed after a read or write.
    typedef enum logic [1:0] {
        JOB_INSTANT = 2'd0,
        JOB_AVERAGE = 2'd1,
        JOB_READ    = 2'd2,
        JOB_WRITE   = 2'd3
    } trm_job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } trm_unit_stat_t;

endpackage

// ===== rtl/trm_scale.sv =====
// Digit-serial multiplier by one million, one hex digit of the constant per cycle.
// Depends on trm_pkg.
module trm_scale
    import trm_pkg::*;
#(
    parameter int CNT_W = 40
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [CNT_W-1:0]          count,
    output logic [CNT_W+USEC_W-1:0]   product,
    output trm_unit_stat_t            stat
);

    localparam int MUL_W = CNT_W + USEC_W;

    logic [CNT_W-1:0]         count_reg;
    logic [MUL_W-1:0]         acc_reg;
    logic [MUL_W-1:0]         acc_next;
    logic [DIGIT_IDX_W-1:0]   idx_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [DIGIT_W-1:0]       digit;
    logic [CNT_W+DIGIT_W-1:0] partial;

    assign digit    = USEC_PER_SEC[idx_reg*DIGIT_W +: DIGIT_W];
    assign partial  = count_reg * digit;
    assign acc_next = {acc_reg[MUL_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + MUL_W'(partial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            idx_reg  <= DIGIT_IDX_W'(USEC_DIGITS - 1);
        end
        else if (busy_reg)
        begin
            if (idx_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            count_reg <= count;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/trm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on trm_pkg.
module trm_div
    import trm_pkg::*;
#(
    parameter int DVD_W = 60,
    parameter int DVS_W = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic [DVD_W-1:0]  quotient,
    output trm_unit_stat_t    stat
);

    localparam int CNT_BITS = $clog2(DVD_W + 1);

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    logic [DVD_W-1:0]    dq_reg;
    logic [DVS_W:0]      rem_reg;
    logic [DVS_W-1:0]    divisor_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DVS_W:0]      rem_shift;
    logic                take;

    assign rem_shift = {rem_reg[DVS_W-1:0], dq_reg[DVD_W-1]};
    assign take      = rem_shift >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_BITS'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg      <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DVD_W-2:0], take};
            rem_reg <= take ? (rem_shift - {1'b0, divisor_reg}) : rem_shift;
        end
    end

    assign quotient  = dq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/transfer_rate_meter.sv =====
// Transfer rate meter top level; depends on trm_pkg, trm_scale, trm_div and
// assert_macros.svh. Each request carries an op, a byte count and a microsecond
// timestamp; exactly one response follows, showing the totals and the four rates
// after that request. Flush and init go straight to the output state, which
// registers the response once the output is free. A read or write recomputes up
// to four rates, each as count * 1e6 / span on one shared unit: the hex-digit
// scaler (start, five digits, done), then the bit-serial divider, one quotient bit
// for each of the M = max(COUNT_WIDTH, BYTES_WIDTH) + 20 dividend bits, then the
// rate is picked; a rate whose span is zero or backward is skipped.
// A new request is taken while the previous response still waits at the output.
module transfer_rate_meter
    import trm_pkg::*;
#(
    parameter int COUNT_WIDTH = 40,
    parameter int TIME_WIDTH  = 48,
    parameter int BYTES_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             op,
    input  logic [BYTES_WIDTH-1:0] byte_count,
    input  logic [TIME_WIDTH-1:0]  now_us,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [RATE_W-1:0]      instant_rate,
    output logic [RATE_W-1:0]      average_rate,
    output logic [RATE_W-1:0]      read_rate,
    output logic [RATE_W-1:0]      write_rate,
    output logic [SUM_W-1:0]       sum_bytes,
    output logic [SUM_W-1:0]       sum_read,
    output logic [SUM_W-1:0]       sum_written
);

`include "assert_macros.svh"

    localparam int CNT_IN_W = (COUNT_WIDTH > BYTES_WIDTH) ? COUNT_WIDTH : BYTES_WIDTH;
    localparam int MUL_W    = CNT_IN_W + USEC_W;
    localparam logic [COUNT_WIDTH-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_JOB,
        S_SCALE,
        S_DIV,
        S_OUT
    } state_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] total,
        input logic [BYTES_WIDTH-1:0] n
    );
        logic [CNT_IN_W:0] sum;
        sum = (CNT_IN_W + 1)'(total) + (CNT_IN_W + 1)'(n);
        if (sum > (CNT_IN_W + 1)'(TOTAL_MAX))
            return TOTAL_MAX;
        return sum[COUNT_WIDTH-1:0];
    endfunction

    state_t                 state_reg;
    trm_job_t               job_reg;
    logic                   scale_start_reg;
    logic                   div_start_reg;
    logic [TIME_WIDTH-1:0]  last_time_reg;
    logic [TIME_WIDTH-1:0]  win_time_reg;
    logic [COUNT_WIDTH-1:0] bytes_total_reg;
    logic [COUNT_WIDTH-1:0] read_total_reg;
    logic [COUNT_WIDTH-1:0] write_total_reg;
    logic [RATE_W-1:0]      rate_reg [4];
    logic [BYTES_WIDTH-1:0] n_reg;
    logic                   inst_ok_reg;
    logic                   win_ok_reg;
    logic [TIME_WIDTH-1:0]  span_inst_reg;
    logic [TIME_WIDTH-1:0]  span_win_reg;

    logic                   out_valid_reg;
    logic [RATE_W-1:0]      out_instant_reg;
    logic [RATE_W-1:0]      out_average_reg;
    logic [RATE_W-1:0]      out_read_reg;
    logic [RATE_W-1:0]      out_write_reg;
    logic [SUM_W-1:0]       out_bytes_reg;
    logic [SUM_W-1:0]       out_read_sum_reg;
    logic [SUM_W-1:0]       out_write_sum_reg;

    logic [COUNT_WIDTH-1:0] read_sum;
    logic [COUNT_WIDTH-1:0] write_sum;
    logic [COUNT_WIDTH-1:0] bytes_sum;
    logic [CNT_IN_W-1:0]    job_count;
    logic [TIME_WIDTH-1:0]  job_span;
    logic                   job_en;
    logic [MUL_W-1:0]       product;
    logic [MUL_W-1:0]       quotient;
    logic [RATE_W-1:0]      rate_q;
    trm_unit_stat_t         scale_stat;
    trm_unit_stat_t         div_stat;
    logic                   totals_ordered;

    assign read_sum  = sat_add(read_total_reg, byte_count);
    assign write_sum = sat_add(write_total_reg, byte_count);
    assign bytes_sum = sat_add(bytes_total_reg, byte_count);

    always_comb
    begin
        job_count = CNT_IN_W'(n_reg);
        job_span  = span_win_reg;
        job_en    = win_ok_reg;
        case (job_reg)
            JOB_INSTANT:
            begin
                job_count = CNT_IN_W'(n_reg);
                job_span  = span_inst_reg;
                job_en    = inst_ok_reg;
            end
            JOB_AVERAGE: job_count = CNT_IN_W'(bytes_total_reg);
            JOB_READ:    job_count = CNT_IN_W'(read_total_reg);
            JOB_WRITE:   job_count = CNT_IN_W'(write_total_reg);
            default:     job_count = CNT_IN_W'(n_reg);
        endcase
    end

    trm_scale #(
        .CNT_W   (CNT_IN_W)
    ) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scale_start_reg),
        .count   (job_count),
        .product (product),
        .stat    (scale_stat)
    );

    trm_div #(
        .DVD_W    (MUL_W),
        .DVS_W    (TIME_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (product),
        .divisor  (job_span),
        .quotient (quotient),
        .stat     (div_stat)
    );

    generate
        if (MUL_W > RATE_W)
        begin : g_rate_sat
            assign rate_q = (|quotient[MUL_W-1:RATE_W]) ? RATE_MAX : quotient[RATE_W-1:0];
        end
        else
        begin : g_rate_ext
            assign rate_q = RATE_W'(quotient);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            job_reg           <= JOB_INSTANT;
            scale_start_reg   <= 1'b0;
            div_start_reg     <= 1'b0;
            last_time_reg     <= '0;
            win_time_reg      <= '0;
            bytes_total_reg   <= '0;
            read_total_reg    <= '0;
            write_total_reg   <= '0;
            for (int i = 0; i < 4; i++)
                rate_reg[i] <= '0;
            n_reg             <= '0;
            inst_ok_reg       <= 1'b0;
            win_ok_reg        <= 1'b0;
            span_inst_reg     <= '0;
            span_win_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_instant_reg   <= '0;
            out_average_reg   <= '0;
            out_read_reg      <= '0;
            out_write_reg     <= '0;
            out_bytes_reg     <= '0;
            out_read_sum_reg  <= '0;
            out_write_sum_reg <= '0;
        end
        else
        begin
            // A rate whose span is zero or backward keeps its old value.
            scale_start_reg <= (state_reg == S_JOB) && job_en;
            div_start_reg   <= (state_reg == S_SCALE) && scale_stat.done;
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (trm_op_t'(op)) inside
                            OP_READ, OP_WRITE:
                            begin
                                if (trm_op_t'(op) == OP_READ)
                                    read_total_reg <= read_sum;
                                else
                                    write_total_reg <= write_sum;
                                bytes_total_reg <= bytes_sum;
                                last_time_reg   <= now_us;
                                n_reg           <= byte_count;
                                inst_ok_reg     <= now_us > last_time_reg;
                                win_ok_reg      <= now_us > win_time_reg;
                                span_inst_reg   <= now_us - last_time_reg;
                                span_win_reg    <= now_us - win_time_reg;
                                job_reg         <= JOB_INSTANT;
                                state_reg       <= S_JOB;
                            end
                            OP_FLUSH:
                            begin
                                bytes_total_reg <= '0;
                                read_total_reg  <= '0;
                                write_total_reg <= '0;
                                for (int i = 0; i < 4; i++)
                                    rate_reg[i] <= '0;
                                win_time_reg    <= now_us;
                                state_reg       <= S_OUT;
                            end
                            OP_INIT:
                            begin
                                bytes_total_reg <= '0;
                                read_total_reg  <= '0;
                                write_total_reg <= '0;
                                for (int i = 0; i < 4; i++)
                                    rate_reg[i] <= '0;
                                win_time_reg    <= now_us;
                                last_time_reg   <= now_us;
                                state_reg       <= S_OUT;
                            end
                        endcase
                    end
                end
                S_JOB:
                begin
                    if (job_en)
                    begin
                        state_reg <= S_SCALE;
                    end
                    else if (job_reg == JOB_WRITE)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        job_reg <= trm_job_t'(job_reg + 2'd1);
                    end
                end
                S_SCALE:
                begin
                    if (scale_stat.done)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        rate_reg[job_reg] <= rate_q;
                        if (job_reg == JOB_WRITE)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            job_reg   <= trm_job_t'(job_reg + 2'd1);
                            state_reg <= S_JOB;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_instant_reg   <= rate_reg[JOB_INSTANT];
                        out_average_reg   <= rate_reg[JOB_AVERAGE];
                        out_read_reg      <= rate_reg[JOB_READ];
                        out_write_reg     <= rate_reg[JOB_WRITE];
                        out_bytes_reg     <= SUM_W'(bytes_total_reg);
                        out_read_sum_reg  <= SUM_W'(read_total_reg);
                        out_write_sum_reg <= SUM_W'(write_total_reg);
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign instant_rate = out_instant_reg;
    assign average_rate = out_average_reg;
    assign read_rate    = out_read_reg;
    assign write_rate   = out_write_reg;
    assign sum_bytes    = out_bytes_reg;
    assign sum_read     = out_read_sum_reg;
    assign sum_written  = out_write_sum_reg;

    assign totals_ordered = (bytes_total_reg >= read_total_reg) &&
                            (bytes_total_reg >= write_total_reg);

    `ASSERT_SAME(a_idle_units_quiet, clk, rst_n, in_ready, !scale_stat.busy && !div_stat.busy)
    `ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_stat.done, state_reg == S_DIV)
    `ASSERT_SAME(a_total_covers_parts, clk, rst_n, 1'b1, totals_ordered)
    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
